>>> hw/rtl/tcvs_pkg.sv
// Package for the three-channel voltage smoother: widths, reset values,
// register indexes and the transfer payload structs.
// No dependencies.
`timescale 1ns / 1ps

package tcvs_pkg;

  localparam int SampleWidth  = 12;
  localparam int GainWidth    = 16;
  localparam int LevelWidth   = 8;
  localparam int SumWidth     = SampleWidth + 4;
  localparam int ProdWidth    = SampleWidth + GainWidth + 1;
  localparam int HiWidth      = ProdWidth - GainWidth;
  localparam int NumChannels  = 3;
  localparam int ChanWidth    = 2;
  localparam int StepWidth    = 3;
  localparam int CapShift     = 2;
  localparam int SupShift     = 3;

  localparam logic [StepWidth-1:0] FirstMulStep  = StepWidth'(1);
  localparam logic [StepWidth-1:0] FirstClipStep = StepWidth'(2);
  localparam logic [StepWidth-1:0] LastStep      = StepWidth'(NumChannels + 1);

  localparam logic [GainWidth-1:0]  CapGainReset = GainWidth'(10244);
  localparam logic [GainWidth-1:0]  SupGainReset = GainWidth'(7463);
  localparam logic [LevelWidth-1:0] LevelMax     = LevelWidth'(255);

  localparam logic [ChanWidth-1:0] ChanCapacitor = ChanWidth'(0);

  typedef enum logic [0:0] {
    CFG_CAPACITOR_GAIN = 1'b0,
    CFG_SUPPLY_GAIN    = 1'b1
  } tcvs_cfg_e;

  typedef struct packed {
    logic                          kind;
    logic signed [SampleWidth-1:0] capacitor_sample;
    logic signed [SampleWidth-1:0] line_sample;
    logic signed [SampleWidth-1:0] supply_sample;
  } tcvs_in_t;

  typedef struct packed {
    logic [LevelWidth-1:0] capacitor_level;
    logic [LevelWidth-1:0] line_level;
    logic [LevelWidth-1:0] supply_level;
  } tcvs_out_t;

  typedef struct packed {
    logic mul_en;
    logic cap_gain_sel;
  } tcvs_scale_ctrl_t;

endpackage

>>> hw/rtl/tcvs_filter.sv
// Shared filter datapath: load or rounded exponential average for one channel.
// Depends on tcvs_pkg.
`timescale 1ns / 1ps

module tcvs_filter (
  input  logic                                   load_i,
  input  logic [tcvs_pkg::ChanWidth-1:0]         chan_i,
  input  logic signed [tcvs_pkg::SampleWidth-1:0] avg_i,
  input  logic signed [tcvs_pkg::SampleWidth-1:0] sample_i,
  output logic signed [tcvs_pkg::SampleWidth-1:0] avg_o
);
  import tcvs_pkg::*;

  logic signed [SumWidth-1:0] avg_ext;
  logic signed [SumWidth-1:0] sample_ext;
  logic signed [SumWidth-1:0] cap_sum;
  logic signed [SumWidth-1:0] sup_sum;
  logic signed [SumWidth-1:0] cap_shifted;
  logic signed [SumWidth-1:0] sup_shifted;

  assign avg_ext    = SumWidth'(avg_i);
  assign sample_ext = SumWidth'(sample_i);

  assign cap_sum = (avg_ext <<< 1) + avg_ext + sample_ext
                   + SumWidth'(1 << (CapShift - 1));
  assign sup_sum = (avg_ext <<< 3) - avg_ext + sample_ext
                   + SumWidth'(1 << (SupShift - 1));

  assign cap_shifted = cap_sum >>> CapShift;
  assign sup_shifted = sup_sum >>> SupShift;

  always_comb begin
    if (load_i) begin
      avg_o = sample_i;
    end else if (chan_i == ChanCapacitor) begin
      avg_o = cap_shifted[SampleWidth-1:0];
    end else begin
      avg_o = sup_shifted[SampleWidth-1:0];
    end
  end

endmodule

>>> hw/rtl/tcvs_scaler.sv
// Shared gain multiplier with registered product, then floor shift and clip
// to an 8-bit level. Depends on tcvs_pkg.
`timescale 1ns / 1ps

module tcvs_scaler (
  input  logic                                    clk_i,
  input  tcvs_pkg::tcvs_scale_ctrl_t              ctrl_i,
  input  logic signed [tcvs_pkg::SampleWidth-1:0] avg_i,
  input  logic [tcvs_pkg::GainWidth-1:0]          cap_gain_i,
  input  logic [tcvs_pkg::GainWidth-1:0]          sup_gain_i,
  output logic [tcvs_pkg::LevelWidth-1:0]         level_o
);
  import tcvs_pkg::*;

  logic signed [GainWidth:0]   gain_ext;
  logic signed [ProdWidth-1:0] prod_d;
  logic signed [ProdWidth-1:0] prod_q;
  logic        [HiWidth-1:0]   hi;

  assign gain_ext = ctrl_i.cap_gain_sel ? {1'b0, cap_gain_i} : {1'b0, sup_gain_i};
  assign prod_d   = avg_i * gain_ext;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  assign hi = prod_q[ProdWidth-1:GainWidth];

  always_comb begin
    if (hi[HiWidth-1]) begin
      level_o = '0;
    end else if (hi > HiWidth'(LevelMax)) begin
      level_o = LevelMax;
    end else begin
      level_o = hi[LevelWidth-1:0];
    end
  end

endmodule

>>> hw/rtl/three_channel_voltage_smoother.sv
// Top level of the three-channel voltage smoother: sequencer, filter state,
// gain registers and output register. Depends on tcvs_pkg, tcvs_filter, tcvs_scaler.
`timescale 1ns / 1ps

// An accepted item is processed by one filter datapath and one multiplier
// shared across the capacitor, line and supply channels (filter, multiply
// and clip overlap one channel apart), and the result is then registered
// in the output register. The block takes no new item until that result is
// registered; a new item may be accepted while the previous result still
// waits on the output. Gain writes take effect at once and are meant for idle.
module three_channel_voltage_smoother (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  tcvs_pkg::tcvs_in_t             in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output tcvs_pkg::tcvs_out_t            out_data_o,
  input  logic                           cfg_we_i,
  input  tcvs_pkg::tcvs_cfg_e            cfg_idx_i,
  input  logic [tcvs_pkg::GainWidth-1:0] cfg_data_i
);
  import tcvs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [StepWidth-1:0] step_q, step_d;

  logic [GainWidth-1:0] cap_gain_q, sup_gain_q;
  logic                 out_valid_q;
  tcvs_out_t            out_q;
  tcvs_in_t             item_q;

  logic signed [SampleWidth-1:0] avg_q [NumChannels];
  logic        [LevelWidth-1:0]  level_q [NumChannels];

  logic                          in_xfer;
  logic                          push;
  logic                          filt_en;
  logic                          clip_en;
  logic [ChanWidth-1:0]          filt_chan;
  logic signed [SampleWidth-1:0] sample_sel;
  logic signed [SampleWidth-1:0] filt_avg;
  logic [LevelWidth-1:0]         level;
  tcvs_scale_ctrl_t              scale_ctrl;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign push       = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  assign filt_chan = step_q[ChanWidth-1:0];
  assign filt_en   = (state_q == ST_RUN) && (step_q < FirstMulStep + StepWidth'(2));
  assign clip_en   = (state_q == ST_RUN) && (step_q >= FirstClipStep);

  assign scale_ctrl.mul_en       = (state_q == ST_RUN) && (step_q >= FirstMulStep)
                                   && (step_q < LastStep);
  assign scale_ctrl.cap_gain_sel = (step_q == FirstMulStep);

  always_comb begin
    case (filt_chan)
      2'd0:    sample_sel = item_q.capacitor_sample;
      2'd1:    sample_sel = item_q.line_sample;
      default: sample_sel = item_q.supply_sample;
    endcase
  end

  tcvs_filter u_filter (
    .load_i   (item_q.kind),
    .chan_i   (filt_chan),
    .avg_i    (avg_q[0]),
    .sample_i (sample_sel),
    .avg_o    (filt_avg)
  );

  tcvs_scaler u_scaler (
    .clk_i      (clk_i),
    .ctrl_i     (scale_ctrl),
    .avg_i      (avg_q[NumChannels-1]),
    .cap_gain_i (cap_gain_q),
    .sup_gain_i (sup_gain_q),
    .level_o    (level)
  );

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_RUN;
          step_d  = '0;
        end
      end
      ST_RUN: begin
        step_d = step_q + StepWidth'(1);
        if (step_q == LastStep) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (push) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  // filter state: rotate so the channel being filtered sits at the head
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChannels; i++) begin
        avg_q[i] <= '0;
      end
    end else if (filt_en) begin
      for (int i = 0; i < NumChannels - 1; i++) begin
        avg_q[i] <= avg_q[i+1];
      end
      avg_q[NumChannels-1] <= filt_avg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_gain_q <= CapGainReset;
      sup_gain_q <= SupGainReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CAPACITOR_GAIN: cap_gain_q <= cfg_data_i;
        CFG_SUPPLY_GAIN:    sup_gain_q <= cfg_data_i;
        default:            ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= in_data_i;
    end
    if (clip_en) begin
      for (int i = 0; i < NumChannels - 1; i++) begin
        level_q[i] <= level_q[i+1];
      end
      level_q[NumChannels-1] <= level;
    end
    if (push) begin
      out_q.capacitor_level <= level_q[0];
      out_q.line_level      <= level_q[1];
      out_q.supply_level    <= level_q[2];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hw/rtl/tcvs_checker.sv
// Port-level checker for the three-channel voltage smoother, bound to the top.
// Depends on tcvs_pkg and three_channel_voltage_smoother.
`timescale 1ns / 1ps

module tcvs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input tcvs_pkg::tcvs_out_t out_data_o
);
  import tcvs_pkg::*;

  logic in_xfer;

  assign in_xfer = in_valid_i && in_ready_o;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !in_ready_o)
    else $error("ready after input transfer");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |-> ##4 !in_ready_o)
    else $error("item finished too early");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> !$rose(out_valid_o))
    else $error("result appeared right after input transfer");

endmodule

bind three_channel_voltage_smoother tcvs_checker u_tcvs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
